>>> design/bsb_pkg.sv
package bsb_pkg;

  // Field and state widths
  localparam int unsigned T_W     = 24;  // sample counter and song length
  localparam int unsigned NB_W    = 3;   // identifier byte count field
  localparam int unsigned SEL_W   = 3;   // formula select
  localparam int unsigned OUT_W   = 12;  // widest sample the formulas give
  localparam int unsigned SQ_W    = 20;  // low bits of t*t that reach a sample
  localparam int unsigned D_W     = T_W - 13;  // divisor (t>>13)&(t>>6)
  localparam int unsigned REM_W   = D_W + 1;
  localparam int unsigned BANK_SIZE = 7;

  localparam logic [T_W-1:0] SONG_RESET = T_W'(11025 * 10);

  // Request codes
  localparam logic REQ_CARD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic [SEL_W-1:0] first;
    logic [SEL_W-1:0] second;
  } choice_t;

  typedef struct packed {
    logic [SQ_W-1:0]  sq;
    logic [REM_W-1:0] rem;
  } ser_res_t;

  // Add one nibble to a residue modulo seven
  function automatic logic [SEL_W-1:0] mod7_add(logic [SEL_W-1:0] acc, logic [3:0] nib);
    logic [4:0] s;
    s = 5'(acc) + 5'(nib);
    if (s >= 5'(3 * BANK_SIZE)) begin
      s = s - 5'(3 * BANK_SIZE);
    end else if (s >= 5'(2 * BANK_SIZE)) begin
      s = s - 5'(2 * BANK_SIZE);
    end else if (s >= 5'(BANK_SIZE)) begin
      s = s - 5'(BANK_SIZE);
    end
    return s[SEL_W-1:0];
  endfunction

  // First bank of formulas, low bits only
  function automatic logic [OUT_W-1:0] bank_one(logic [SEL_W-1:0] sel, logic [T_W-1:0] t);
    logic [31:0] t32;
    logic [31:0] m;
    logic [31:0] r;
    logic [11:0] p;
    t32 = 32'(t);
    m   = '0;
    p   = '0;
    case (sel)
      3'd0: r = (t32 & (t32 >> 6)) | ((t32 >> 2) & 32'hFF);
      3'd1: r = (t32 << 1) & (((t32 >> 4) | (t32 >> 14)) & 32'h7F);
      3'd2: begin
        m = ((t32 >> 3) | (t32 >> 9)) & 32'd64 & (t32 >> 2);
        r = m[6] ? (t32 << 6) : 32'd0;
      end
      3'd3: r = (((t32 << 2) + t32) & (t32 >> 7)) | (((t32 << 1) + t32) & (t32 >> 10));
      3'd4: begin
        m = (t32 & ((t32 << 1) >> 16)) | (t32 & ((t32 << 1) >> 8));
        r = (m << 1) & 32'h7F;
      end
      3'd5: begin
        m = (t32 >> 12) | (t32 >> 6);
        p = 12'(t32[5:0]) * 12'(m[5:0]);
        r = p[5] ? 32'd64 : 32'd0;
      end
      default: begin
        m = (((t32 << 1) + t32) >> 4) | ((t32 << 1) >> 10);
        p = 12'(t32[5:0]) * 12'(m[5:0]);
        r = p[5] ? 32'd64 : 32'd0;
      end
    endcase
    return r[OUT_W-1:0];
  endfunction

  // Second bank of formulas, low bits only; square and remainder come from the serial unit
  function automatic logic [OUT_W-1:0] bank_two(logic [SEL_W-1:0] sel, logic [T_W-1:0] t,
                                                ser_res_t ser);
    logic [31:0] t32;
    logic [31:0] m;
    logic [31:0] r;
    logic [31:0] rem32;
    logic [9:0]  p;
    t32   = 32'(t);
    rem32 = 32'(ser.rem);
    m     = '0;
    p     = '0;
    case (sel)
      3'd0: begin
        m = (t32 >> 13) & (t32 >> 6);
        r = (m == 32'd0) ? 32'd0 : ((rem32 << 3) - rem32);
      end
      3'd1: r = (32'(ser.sq) >> 8) & (t32 >> t32[13:10]);
      3'd2: r = (32'(ser.sq) >> 7) & (t32 >> t32[11:8]);
      3'd3: begin
        m = (t32 >> 10) | (t32 >> 5);
        p = 10'(t32[4:0]) * 10'(m[4:0]);
        r = p[4] ? 32'd32 : 32'd0;
      end
      3'd4: begin
        m = (t32 >> 14) | (t32 >> 12);
        p = 10'({t32[3:0], 1'b0}) * 10'(m[4:0]);
        r = p[4] ? 32'd32 : 32'd0;
      end
      3'd5: begin
        m = (t32 >> 9) | (t32 >> 13);
        p = 10'(t32[4:0]) * 10'(m[4:0]);
        r = p[4] ? 32'd32 : 32'd0;
      end
      default: begin
        m = (t32 >> 14) | (t32 >> 10);
        p = 10'(t32[3:0]) * 10'(m[3:0]);
        r = p[3] ? 32'd64 : 32'd0;
      end
    endcase
    return r[OUT_W-1:0];
  endfunction

endpackage

>>> design/bsb_if.sv
interface bsb_req_if #(
  parameter int unsigned UID_W = 56
);
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [UID_W-1:0]          uid_value;
  logic [bsb_pkg::NB_W-1:0]  uid_bytes;

  modport source (output valid, output req_type, output uid_value, output uid_bytes,
                  input ready);
  modport sink   (input valid, input req_type, input uid_value, input uid_bytes,
                  output ready);
endinterface

interface bsb_smp_if #(
  parameter int unsigned SAMPLE_BITS = 8
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

>>> design/bsb_uid_hash.sv
module bsb_uid_hash #(
  parameter int unsigned MAX_ID_BYTES = 7
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [8*MAX_ID_BYTES-1:0] uid_i,
  input  logic [bsb_pkg::NB_W-1:0] nbytes_i,
  output logic                     done_o,
  output bsb_pkg::choice_t         choice_o
);
  import bsb_pkg::*;

  localparam int unsigned UID_W = 8 * MAX_ID_BYTES;
  localparam int unsigned CNT_W = $clog2(MAX_ID_BYTES + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [UID_W-1:0] uid_q;
  choice_t          acc_q;
  logic [7:0]       cur_byte;
  logic [CNT_W-1:0] n_clamp;

  assign cur_byte = uid_q[UID_W-1 -: 8];
  assign done_o   = busy_q && (cnt_q == '0);
  assign choice_o = acc_q;

  // Clamp the byte count to the identifier size
  always_comb begin
    if (32'(nbytes_i) > MAX_ID_BYTES) begin
      n_clamp = CNT_W'(MAX_ID_BYTES);
    end else begin
      n_clamp = CNT_W'(nbytes_i);
    end
  end

  // Count down the remaining bytes
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = n_clamp;
    end else if (done_o) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      acc_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      // Fold one byte a cycle into the two residues
      if (start_i) begin
        acc_q <= '0;
      end else if (busy_q && (cnt_q != '0)) begin
        acc_q.first  <= mod7_add(acc_q.first, cur_byte[7:4]);
        acc_q.second <= mod7_add(acc_q.second, cur_byte[3:0]);
      end
    end
  end

  // Shift the identifier up one byte a cycle, first byte on top
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      uid_q <= uid_i;
    end else if (busy_q) begin
      uid_q <= uid_q << 8;
    end
  end

endmodule

>>> design/bsb_serial_unit.sv
module bsb_serial_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [bsb_pkg::T_W-1:0] t_i,
  output logic                    done_o,
  output bsb_pkg::ser_res_t       res_o
);
  import bsb_pkg::*;

  localparam int unsigned CNT_W = $clog2(T_W);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SQ_W-1:0]  mpl_q;
  logic [SQ_W-1:0]  mcd_q;
  logic [SQ_W-1:0]  acc_q;
  logic [T_W-1:0]   div_q;
  logic [D_W-1:0]   d_q;
  logic [REM_W-1:0] rem_q;
  logic [REM_W-1:0] r_sh;

  assign done_o    = busy_q && (cnt_q == '0);
  assign res_o.sq  = acc_q;
  assign res_o.rem = rem_q;

  // Bring down the next dividend bit, MSB first
  assign r_sh = {rem_q[D_W-1:0], div_q[T_W-1]};

  // Step counter: one bit of t per cycle
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(T_W - 1);
    end else if (done_o) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Shift-add square and restoring remainder, side by side
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mpl_q <= t_i[SQ_W-1:0];
      mcd_q <= t_i[SQ_W-1:0];
      acc_q <= '0;
      div_q <= t_i;
      d_q   <= t_i[T_W-1 -: D_W] & t_i[6 +: D_W];
      rem_q <= '0;
    end else if (busy_q) begin
      mpl_q <= mpl_q >> 1;
      mcd_q <= mcd_q << 1;
      if (mpl_q[0]) begin
        acc_q <= acc_q + mcd_q;
      end
      div_q <= div_q << 1;
      if (r_sh >= {1'b0, d_q}) begin
        rem_q <= r_sh - {1'b0, d_q};
      end else begin
        rem_q <= r_sh;
      end
    end
  end

endmodule

>>> design/card_seeded_bytebeat_synth.sv
// Channel   Direction  Handshake     Payload
// in_if     sink       valid/ready   req_type, uid_value, uid_bytes
// out_if    source     valid/ready   sample, last_sample
// cfg       write      cfg_we_i      cfg_wdata_i (song length)
//
// A card item goes through the hash shifter one byte a cycle.
// A tick item while playing enters the calc state, runs in the bit-serial square and
// remainder unit, then loads the output register from the done state.
// Reset: idle, song length 110250, counter and formula selects cleared.
// A waiting result does not block input; a finished tick waits for the output register.
module card_seeded_bytebeat_synth #(
  parameter int unsigned MAX_ID_BYTES = 7,
  parameter int unsigned SAMPLE_BITS  = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  bsb_req_if.sink                 in_if,
  bsb_smp_if.source               out_if,
  input  logic                    cfg_we_i,
  input  logic [bsb_pkg::T_W-1:0] cfg_wdata_i
);
  import bsb_pkg::*;

  localparam int unsigned UID_W = 8 * MAX_ID_BYTES;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HASH = 5'b00010,
    S_PLAY = 5'b00100,
    S_CALC = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  logic [T_W-1:0]         idx_q, idx_d;
  logic [T_W-1:0]         song_q;
  logic                   out_vld_q, out_vld_d;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic                   last_q;

  logic                   in_acc;
  logic                   hash_start, hash_done;
  logic                   ser_start, ser_done;
  logic                   out_load;
  logic                   is_last;
  logic [T_W-1:0]         len_m1;
  logic [OUT_W-1:0]       mix;
  choice_t                choice;
  ser_res_t               ser_res;

  bsb_uid_hash #(
    .MAX_ID_BYTES(MAX_ID_BYTES)
  ) u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (hash_start),
    .uid_i    (UID_W'(in_if.uid_value)),
    .nbytes_i (in_if.uid_bytes),
    .done_o   (hash_done),
    .choice_o (choice)
  );

  bsb_serial_unit u_ser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ser_start),
    .t_i     (idx_q),
    .done_o  (ser_done),
    .res_o   (ser_res)
  );

  assign in_if.ready = (state_q == S_IDLE) || (state_q == S_PLAY);
  assign in_acc      = in_if.valid && in_if.ready;

  // Last sample test; a zero length plays one sample
  assign len_m1  = (song_q == '0) ? '0 : song_q - 1'b1;
  assign is_last = idx_q >= len_m1;

  // Mix the two banks
  assign mix = bank_one(choice.first, idx_q) + bank_two(choice.second, idx_q, ser_res);

  // Sequence cards and ticks
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    hash_start = 1'b0;
    ser_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_if.req_type == REQ_CARD)) begin
          hash_start = 1'b1;
          state_d    = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          idx_d   = '0;
          state_d = S_PLAY;
        end
      end
      S_PLAY: begin
        if (in_acc && (in_if.req_type == REQ_TICK)) begin
          ser_start = 1'b1;
          state_d   = S_CALC;
        end
      end
      S_CALC: begin
        if (ser_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_vld_q || out_if.ready) begin
          out_load = 1'b1;
          if (is_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_PLAY;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the output item until taken
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_if.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
      song_q    <= SONG_RESET;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        song_q <= cfg_wdata_i;
      end
    end
  end

  // Load the output payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sample_q <= mix[SAMPLE_BITS-1:0];
      last_q   <= is_last;
    end
  end

  assign out_if.valid       = out_vld_q;
  assign out_if.sample      = sample_q;
  assign out_if.last_sample = last_q;

  // A new output item comes only from the done state
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_DONE))
    else $error("output item raised outside the done state");

  // The serial unit finishes only while a tick is being worked
  a_ser_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_done |-> (state_q == S_CALC))
    else $error("serial unit finished outside the calc state");

  // The final sample of a song returns the block to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && is_last) |=> (state_q == S_IDLE))
    else $error("last sample did not end playback");

endmodule

>>> tb/sv/bsb_checker.sv
module bsb_checker (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  bsb_req_if                      req_if,
  bsb_smp_if                      smp_if,
  input  logic                    cfg_we_i,
  input  logic [bsb_pkg::T_W-1:0] cfg_wdata_i,
  output int                      mismatch_count_o,
  output int                      pending_o
);
  import bsb_pkg::*;

  localparam int unsigned ID_BYTES = 7;

  typedef struct packed {
    logic [7:0] sample;
    logic       last_sample;
  } sample_item_t;

  // Samples owed by the block, oldest first
  sample_item_t expected_samples[$];

  // Own copy of the synth state and the song length register
  logic [T_W-1:0]   song_len;
  logic [T_W-1:0]   play_pos;
  logic             song_on;
  logic [SEL_W-1:0] tone_sel;
  logic [SEL_W-1:0] rhythm_sel;
  int               mismatches;

  assign mismatch_count_o = mismatches;

  // First formula bank, full 32-bit wrap-around arithmetic
  function automatic logic [31:0] tone_value(logic [SEL_W-1:0] sel, logic [31:0] t);
    logic [31:0] prod;
    logic [31:0] twice;
    logic [31:0] mix;
    twice = t * 32'd2;
    case (sel)
      3'd0: return (t & (t >> 6)) | ((t >> 2) % 32'd256);
      3'd1: return twice & (((t >> 4) | (t >> 14)) % 32'd128);
      3'd2: begin
        prod = t * (((t >> 3) | (t >> 9)) & 32'd64 & (t >> 2));
        return prod;
      end
      3'd3: return ((t * 32'd5) & (t >> 7)) | ((t * 32'd3) & (t >> 10));
      3'd4: begin
        mix = (t & (twice >> 16)) | (t & (twice >> 8));
        prod = mix * 32'd2;
        return prod % 32'd128;
      end
      3'd5: begin
        prod = t * ((t >> 12) | (t >> 6));
        return (prod & 32'd32) * 32'd2;
      end
      default: begin
        mix = t * 32'd3;
        prod = t * ((mix >> 4) | (twice >> 10));
        return (prod & 32'd32) * 32'd2;
      end
    endcase
  endfunction

  // Second formula bank; the remainder formula gives zero on a zero divisor
  function automatic logic [31:0] rhythm_value(logic [SEL_W-1:0] sel, logic [31:0] t);
    logic [31:0] sq;
    logic [31:0] divisor;
    logic [31:0] prod;
    sq = t * t;
    case (sel)
      3'd0: begin
        divisor = (t >> 13) & (t >> 6);
        if (divisor == 32'd0) return 32'd0;
        prod = (t % divisor) * 32'd7;
        return prod;
      end
      3'd1: return (sq / 32'd256) & (t >> ((t / 32'd1024) % 32'd16));
      3'd2: return (sq / 32'd128) & (t >> ((t / 32'd256) % 32'd16));
      3'd3: begin
        prod = t * ((t >> 10) | (t >> 5));
        return (prod & 32'd16) * 32'd2;
      end
      3'd4: begin
        prod = (t * 32'd2) * ((t >> 14) | (t >> 12));
        return (prod & 32'd16) * 32'd2;
      end
      3'd5: begin
        prod = t * ((t >> 9) | (t >> 13));
        return (prod & 32'd16) * 32'd2;
      end
      default: begin
        prod = t * ((t >> 14) | (t >> 10));
        return (prod & 32'd8) * 32'd8;
      end
    endcase
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  // Retire one sample against the oldest one owed
  task automatic check_sample(logic [7:0] got_sample, logic got_last);
    sample_item_t want;
    if (expected_samples.size() == 0) begin
      report_mismatch($sformatf("sample %02h last %0b with none owed", got_sample, got_last));
    end else begin
      want = expected_samples.pop_front();
      if (got_sample !== want.sample) begin
        report_mismatch($sformatf("sample %02h, want %02h", got_sample, want.sample));
      end
      if (got_last !== want.last_sample) begin
        report_mismatch($sformatf("last_sample %0b, want %0b", got_last, want.last_sample));
      end
    end
  endtask

  // Hash the identifier nibbles into the two formula selects and start the song, unless one is playing
  task automatic take_card(logic [55:0] uid, logic [NB_W-1:0] nbytes);
    int unsigned hi_sum;
    int unsigned lo_sum;
    int unsigned count;
    logic [7:0]  id_byte;
    if (song_on) return;
    hi_sum = 0;
    lo_sum = 0;
    count  = (nbytes > ID_BYTES) ? ID_BYTES : nbytes;
    for (int i = 0; i < count; i++) begin
      id_byte = uid[8*(ID_BYTES-1-i) +: 8];
      hi_sum += id_byte[7:4];
      lo_sum += id_byte[3:0];
    end
    tone_sel   = SEL_W'(hi_sum % BANK_SIZE);
    rhythm_sel = SEL_W'(lo_sum % BANK_SIZE);
    play_pos   = '0;
    song_on    = 1'b1;
  endtask

  // Owe one sample for a tick while playing, then advance or stop
  task automatic take_tick();
    logic [31:0]  t;
    logic [31:0]  eff_len;
    logic [31:0]  mixed;
    sample_item_t item;
    if (!song_on) return;
    eff_len = (song_len == '0) ? 32'd1 : 32'(song_len);
    t       = 32'(play_pos);
    mixed   = tone_value(tone_sel, t) + rhythm_value(rhythm_sel, t);
    item.sample      = mixed[7:0];
    item.last_sample = (t >= eff_len - 32'd1);
    expected_samples.push_back(item);
    if (item.last_sample) begin
      song_on = 1'b0;
    end else begin
      play_pos = T_W'(t + 32'd1);
    end
  endtask

  // Watch both channels and the register port at every edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      song_len   = SONG_RESET;
      play_pos   = '0;
      song_on    = 1'b0;
      tone_sel   = '0;
      rhythm_sel = '0;
      expected_samples.delete();
      pending_o <= 0;
    end else begin
      if (smp_if.valid && smp_if.ready) begin
        check_sample(smp_if.sample, smp_if.last_sample);
      end
      if (req_if.valid && req_if.ready) begin
        if (req_if.req_type == REQ_CARD) begin
          take_card(req_if.uid_value, req_if.uid_bytes);
        end else begin
          take_tick();
        end
      end
      if (cfg_we_i) begin
        song_len = cfg_wdata_i;
      end
      pending_o <= expected_samples.size();
    end
  end

endmodule

>>> tb/sv/tb.sv
module tb;
  import bsb_pkg::*;

  localparam int unsigned WATCHDOG_MAX  = 2000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned RANDOM_ITEMS  = 700;
  localparam int unsigned LONG_SONG     = 120;
  localparam logic [T_W-1:0] LEN_MAX    = '1;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           cfg_we_i;
  logic [T_W-1:0] cfg_wdata_i;
  int             mismatch_count;
  int             pending;
  int unsigned    quiet_cycles;
  bit             src_idle_en;
  bit             snk_idle_en;

  // Rough view of the song, used only to plan the stimulus
  bit             song_on;
  logic [T_W-1:0] song_pos;
  logic [T_W-1:0] song_len;

  bsb_req_if #(.UID_W(56))      in_if ();
  bsb_smp_if #(.SAMPLE_BITS(8)) out_if ();

  card_seeded_bytebeat_synth dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .out_if      (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  bsb_checker chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_if           (in_if),
    .smp_if           (out_if),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // End the run when neither channel moves an item for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Sample sink: stall a random number of cycles before taking each item
  initial begin
    int unsigned stall;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = snk_idle_en ? $urandom_range(0, 7) : 0;
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (out_if.valid !== 1'b1) @(posedge clk_i);
    end
  end

  function automatic logic [55:0] rand_uid();
    return 56'({$urandom(), $urandom()});
  endfunction

  // Mostly the usual 4 or 7 bytes, now and then any count
  function automatic logic [NB_W-1:0] rand_count();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return NB_W'(4);
    if (pick < 8) return NB_W'(7);
    return NB_W'($urandom_range(0, 7));
  endfunction

  // Offer one item after a random gap and hold it until taken
  task automatic send_item(logic kind, logic [55:0] uid, logic [NB_W-1:0] nbytes);
    int unsigned gap;
    gap = src_idle_en ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.req_type  <= kind;
    in_if.uid_value <= uid;
    in_if.uid_bytes <= nbytes;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
  endtask

  task automatic send_card(logic [55:0] uid, logic [NB_W-1:0] nbytes);
    send_item(REQ_CARD, uid, nbytes);
    if (!song_on) begin
      song_on  = 1'b1;
      song_pos = '0;
    end
  endtask

  task automatic send_tick();
    logic [T_W:0] eff_len;
    send_item(REQ_TICK, rand_uid(), NB_W'($urandom_range(0, 7)));
    eff_len = (song_len == '0) ? (T_W+1)'(1) : (T_W+1)'(song_len);
    if (song_on) begin
      if ((T_W+1)'(song_pos) >= eff_len - 1) begin
        song_on = 1'b0;
      end else begin
        song_pos = song_pos + 1'b1;
      end
    end
  endtask

  // Drop valid, wait for every owed sample, then let the block finish a card
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_length(logic [T_W-1:0] len);
    cfg_wdata_i <= len;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    song_len     = len;
  endtask

  initial begin
    logic [3:0]  hi_nib;
    logic [3:0]  lo_nib;
    int unsigned counted;
    int unsigned pick;

    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.req_type  <= REQ_TICK;
    in_if.uid_value <= '0;
    in_if.uid_bytes <= '0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    src_idle_en      = 1'b1;
    snk_idle_en      = 1'b1;
    song_on          = 1'b0;
    song_pos         = '0;
    song_len         = SONG_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: tick while idle, empty identifier, card while playing
    send_tick();
    send_card('1, NB_W'(0));
    send_tick();
    send_tick();
    send_card('0, NB_W'(7));
    send_tick();
    // Cut the reset-length song short right at the next sample
    settle();
    write_length(T_W'(4));
    send_tick();
    send_tick();
    // Zero length plays one sample, which is also the last
    settle();
    write_length('0);
    send_card('1, NB_W'(7));
    send_tick();
    settle();
    write_length(T_W'(1));
    send_card('0, NB_W'(7));
    send_tick();
    send_card(rand_uid(), NB_W'(4));
    send_tick();
    // Longest song: a few samples, an ignored card, then stop it
    settle();
    write_length(LEN_MAX);
    send_card(rand_uid(), NB_W'(7));
    send_tick();
    send_tick();
    send_tick();
    send_card(rand_uid(), NB_W'(7));
    settle();
    write_length(T_W'(4));
    send_tick();

    // Back-to-back song on the remainder formula
    settle();
    write_length(T_W'(LONG_SONG));
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    hi_nib = 4'($urandom_range(0, 15));
    lo_nib = 4'(7 * $urandom_range(0, 2));
    send_card({hi_nib, lo_nib, 48'({$urandom(), $urandom()})}, NB_W'(1));
    repeat (LONG_SONG) send_tick();

    // Random songs with ignored cards and idle ticks mixed in
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (!song_on) begin
        if ($urandom_range(0, 1) == 0) begin
          settle();
          pick = $urandom_range(0, 15);
          if (pick == 0) begin
            write_length('0);
          end else if (pick == 1) begin
            write_length(T_W'($urandom_range(13, 64)));
          end else begin
            write_length(T_W'($urandom_range(1, 12)));
          end
        end
        if ($urandom_range(0, 7) == 0) begin
          send_tick();
        end else begin
          src_idle_en = ($urandom_range(0, 3) != 0);
          snk_idle_en = ($urandom_range(0, 3) != 0);
          send_card(rand_uid(), rand_count());
          counted++;
        end
      end else if ($urandom_range(0, 9) == 0) begin
        send_card(rand_uid(), rand_count());
      end else begin
        send_tick();
        counted++;
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/bsb_pkg.sv
design/bsb_if.sv
design/bsb_uid_hash.sv
design/bsb_serial_unit.sv
design/card_seeded_bytebeat_synth.sv
tb/sv/bsb_checker.sv
tb/sv/tb.sv
